// ===== rtl/nff_pkg.sv =====
// Shared constants for the normalized FIR filter.
`default_nettype none

package nff_pkg;

  // Sample and result width.
  localparam int DATA_W = 32;

  // Tap registers: count, width and index widths.
  localparam int NUM_REGS    = 8;
  localparam int TAP_W       = 16;
  localparam int TAP_IDX_W   = 3;
  localparam int CFG_INDEX_W = 4;

  // Product of one sample and one tap.
  localparam int PROD_W = DATA_W + TAP_W;

  // Default window length.
  localparam int TAPS_DEFAULT = 8;

  // Reset value of tap_0 (1.0 in Q2.14); the other taps reset to zero.
  localparam logic signed [TAP_W-1:0] TAP0_RESET = 16'sd16384;

endpackage

`default_nettype wire

// ===== rtl/nff_hist_mem.sv =====
// Sample history memory: one write port, one read port with registered data.
`default_nettype none

module nff_hist_mem #(
  parameter int DEPTH  = nff_pkg::TAPS_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [nff_pkg::DATA_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output      logic [nff_pkg::DATA_W-1:0] rdata
);

  logic [nff_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nff_divider.sv =====
// Serial signed divider, one quotient bit per cycle, with saturation to 32 bits.
`default_nettype none

module nff_divider #(
  parameter int NUM_W = nff_pkg::PROD_W + $clog2(nff_pkg::TAPS_DEFAULT),
  parameter int DEN_W = nff_pkg::TAP_W + $clog2(nff_pkg::TAPS_DEFAULT)
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [NUM_W-1:0]           num,
  input  wire logic signed [DEN_W-1:0]           den,
  output      logic                              done,
  output      logic signed [nff_pkg::DATA_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(32'h7FFF_FFFF);
  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(33'h0_8000_0000);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] q;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] d;
  logic             neg;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;

  assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
  assign rem_sh  = {rem, q[NUM_W-1]};
  assign diff    = rem_sh - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division: the dividend shifts out of q while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num_mag;
      rem <= '0;
      d   <= den_mag;
      neg <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (run) begin
      if (!diff[DEN_W]) begin
        rem <= diff[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DEN_W-1:0];
        q   <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg) begin
      if (q > NEG_LIM) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = $signed(~q[nff_pkg::DATA_W-1:0] + 32'd1);
      end
    end else begin
      if (q > POS_LIM) begin
        quot = 32'sh7FFF_FFFF;
      end else begin
        quot = $signed(q[nff_pkg::DATA_W-1:0]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/normalized_fir_filter.sv =====
// Top level of the normalized FIR filter: tap registers, MAC sequencer and output register.
//
// Usage: samples enter on in_valid/in_stall/sample, one result leaves per sample on
// out_valid/out_stall with filtered, warming_up and zero_tap_sum. A transfer happens
// at a rising edge where valid is high and stall is low.
// Taps must be written through cfg_write/cfg_index/cfg_data while the block is idle;
// the block itself does not enforce this. Indexes past tap_7 are ignored, and only the
// first TAPS taps weight samples. One sample is in work at a time; in_stall stays high
// until its result has moved into the output register, so the next sample can be taken
// while that result waits. The first TAPS samples and any sample seen while the taps
// sum to zero pass through: each waits in ST_DONE until the output register is free.
// A filtered sample reads the history memory once per tap (one read port), runs the
// products through a multiply-accumulate pipeline, then a serial divider that makes
// one quotient bit per cycle. The accumulator is ACC_W = 48 + clog2(TAPS) bits wide.
// While out_stall holds, the result stays in the output register and the block can
// finish one more sample behind it before it stalls its input.
// Reset empties the history window, drops out_valid and restores the tap defaults.
// The history memory needs no clearing: every entry is written during warm-up.
`default_nettype none

module normalized_fir_filter #(
  parameter int TAPS = nff_pkg::TAPS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire logic signed [nff_pkg::DATA_W-1:0]    sample,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      logic signed [nff_pkg::DATA_W-1:0]    filtered,
  output      logic                                 warming_up,
  output      logic                                 zero_tap_sum,
  input  wire logic                                 cfg_write,
  input  wire logic [nff_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [nff_pkg::TAP_W-1:0]            cfg_data
);

  localparam int ADDR_W = $clog2(TAPS);
  localparam int CNT_W  = $clog2(TAPS + 1);
  localparam int W_W    = nff_pkg::TAP_W + $clog2(TAPS);
  localparam int ACC_W  = nff_pkg::PROD_W + $clog2(TAPS);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;

  logic signed [nff_pkg::TAP_W-1:0] taps [nff_pkg::NUM_REGS];
  logic signed [W_W-1:0]            tap_sum;
  logic signed [W_W-1:0]            weight_total;

  logic [ADDR_W-1:0] write_slot;
  logic [CNT_W-1:0]  fill_count;

  logic                               accept;
  logic                               ren;
  logic [ADDR_W-1:0]                  rd_pos;
  logic [CNT_W-1:0]                   issue_cnt;
  logic [CNT_W-1:0]                   mac_cnt;
  logic                               rd_v;
  logic [nff_pkg::TAP_IDX_W-1:0]      rd_k;
  logic [nff_pkg::DATA_W-1:0]         rdata;
  logic                               prod_v;
  logic signed [nff_pkg::PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]            acc;

  logic                               div_start;
  logic                               div_done;
  logic signed [nff_pkg::DATA_W-1:0]  div_quot;

  logic signed [nff_pkg::DATA_W-1:0]  res_val;
  logic                               res_warm;
  logic                               res_zero;
  logic                               out_load;

  // Tap registers and their running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < nff_pkg::NUM_REGS; k++) begin
        taps[k] <= '0;
      end
      taps[0] <= nff_pkg::TAP0_RESET;
    end else if (cfg_write && (cfg_index < nff_pkg::CFG_INDEX_W'(nff_pkg::NUM_REGS))) begin
      taps[cfg_index[nff_pkg::TAP_IDX_W-1:0]] <= $signed(cfg_data);
    end
  end

  always_comb begin
    tap_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      tap_sum = tap_sum + W_W'(taps[k]);
    end
  end

  // The sum follows a tap write at once, so a sample right behind the write sees it.
  assign weight_total = tap_sum;

  assign in_stall  = rst || (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ren       = (state == ST_MAC) && (issue_cnt < CNT_W'(TAPS));
  assign div_start = (state == ST_MAC) && (mac_cnt == CNT_W'(TAPS));
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  nff_hist_mem #(
    .DEPTH (TAPS),
    .ADDR_W(ADDR_W)
  ) u_hist (
    .clk  (clk),
    .we   (accept),
    .waddr(write_slot),
    .wdata(sample),
    .re   (ren),
    .raddr(rd_pos),
    .rdata(rdata)
  );

  nff_divider #(
    .NUM_W(ACC_W),
    .DEN_W(W_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (acc),
    .den  (weight_total),
    .done (div_done),
    .quot (div_quot)
  );

  // Sequencer and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      fill_count <= '0;
      issue_cnt  <= '0;
      mac_cnt    <= '0;
      rd_v       <= 1'b0;
      prod_v     <= 1'b0;
    end else begin
      rd_v   <= ren;
      prod_v <= rd_v;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            write_slot <= (write_slot == ADDR_W'(TAPS - 1)) ? '0 : write_slot + 1'b1;
            issue_cnt  <= '0;
            mac_cnt    <= '0;
            if (fill_count < CNT_W'(TAPS)) begin
              fill_count <= fill_count + 1'b1;
              state      <= ST_DONE;
            end else if (weight_total == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MAC;
            end
          end
        end
        ST_MAC: begin
          if (ren) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (prod_v) begin
            mac_cnt <= mac_cnt + 1'b1;
          end
          if (div_start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: read positions walk backward from the newest sample.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pos   <= write_slot;
      acc      <= '0;
      res_val  <= sample;
      res_warm <= (fill_count < CNT_W'(TAPS));
      res_zero <= (fill_count >= CNT_W'(TAPS)) && (weight_total == '0);
    end else begin
      if (ren) begin
        rd_pos <= (rd_pos == '0) ? ADDR_W'(TAPS - 1) : rd_pos - 1'b1;
      end
      if (prod_v) begin
        acc <= acc + ACC_W'(prod);
      end
      if (div_done) begin
        res_val <= div_quot;
      end
    end
    if (ren) begin
      rd_k <= nff_pkg::TAP_IDX_W'(issue_cnt);
    end
    if (rd_v) begin
      prod <= nff_pkg::PROD_W'($signed(rdata)) * nff_pkg::PROD_W'(taps[rd_k]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered     <= res_val;
      warming_up   <= res_warm;
      zero_tap_sum <= res_zero;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(warming_up && zero_tap_sum))
    else $error("warm-up and zero tap sum flagged together");

  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again before the result was produced");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (weight_total != '0))
    else $error("division started with a zero tap sum");

  a_mac_order: assert property (@(posedge clk) disable iff (rst)
    (mac_cnt <= issue_cnt) && (issue_cnt <= CNT_W'(TAPS)))
    else $error("accumulate count ran ahead of memory reads");

endmodule

`default_nettype wire
